// ===== rtl/tvf_pkg.sv =====
package tvf_pkg;

   localparam int VOXEL_COUNT_DEFAULT = 65536;
   localparam int FIFO_DEPTH = 2;
   localparam int DIV_W = 48;
   localparam int DIV_STEP_W = 6;
   localparam logic [DIV_STEP_W-1:0] FULL_STEPS = 6'd48;
   localparam logic [29:0] WEIGHT_MAX = 30'h3FFF_FFFF;
   localparam logic ACT_FUSE = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef enum logic [1:0] {
      CSR_DROP_START = 2'd0,
      CSR_DROP_END   = 2'd1,
      CSR_WEIGHT_CAP = 2'd2,
      CSR_UNOBSERVED = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic               action;
      logic [15:0]        voxel_index;
      logic signed [15:0] signed_distance;
      logic [31:0]        ray_sq_norm;
   } req_type;

   typedef struct packed {
      logic [15:0]        result_index;
      logic signed [15:0] result_distance;
      logic [29:0]        result_weight;
      logic               skipped;
      logic               observed;
   } rsp_type;

   typedef struct packed {
      logic [14:0] drop_start;
      logic [14:0] drop_end;
      logic [29:0] weight_cap;
      logic [14:0] unobserved_distance;
   } cfg_type;

   typedef struct packed {
      logic               is_read;
      logic               far;
      logic [15:0]        voxel_index;
      logic signed [15:0] signed_distance;
      logic [DIV_W-1:0]   w_num;
      logic [DIV_W-1:0]   w_den;
   } cmd_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_MOD,
      B_SLOT,
      B_RD,
      B_DECIDE,
      B_WDIV,
      B_MUL,
      B_SUM,
      B_ABS,
      B_START,
      B_ADIV,
      B_EMIT
   } back_state_type;

endpackage

// ===== rtl/tvf_fifo.sv =====
module tvf_fifo #(
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);
   import tvf_pkg::*;

   localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   item_type        store_ff [FIFO_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tvf_front.sv =====
module tvf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  tvf_pkg::req_type accept_data,
   input  tvf_pkg::cfg_type cfg,
   output logic             holding,
   input  logic             cmd_full,
   output logic             cmd_push,
   output tvf_pkg::cmd_type cmd_data
);
   import tvf_pkg::*;

   req_type            item_ff, item_in;
   logic               valid_ff, valid_in;
   logic [31:0]        ray;
   logic signed [16:0] dist_x, end_x, start_x, dist_plus_end;
   logic [14:0]        span;
   logic [46:0]        den_prod;
   logic               taper;

   assign holding  = valid_ff;
   assign cmd_push = valid_ff && !cmd_full;

   always_comb begin
      ray           = (item_ff.ray_sq_norm == '0) ? 32'd1 : item_ff.ray_sq_norm;
      dist_x        = {item_ff.signed_distance[15], item_ff.signed_distance};
      end_x         = $signed({2'b00, cfg.drop_end});
      start_x       = $signed({2'b00, cfg.drop_start});
      dist_plus_end = dist_x + end_x;
      span          = cfg.drop_end - cfg.drop_start;
      den_prod      = ray * span;
      taper         = (cfg.drop_end > cfg.drop_start) && (dist_x <= -start_x);

      cmd_data.is_read         = (item_ff.action == ACT_READ);
      cmd_data.far             = (dist_x < -end_x);
      cmd_data.voxel_index     = item_ff.voxel_index;
      cmd_data.signed_distance = item_ff.signed_distance;
      if (taper) begin
         cmd_data.w_num = {1'b0, dist_plus_end[14:0], 32'd0};
         cmd_data.w_den = {1'b0, den_prod};
      end else begin
         cmd_data.w_num = 48'h1_0000_0000;
         cmd_data.w_den = {16'd0, ray};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = accept_data;
      end else if (cmd_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ===== rtl/tvf_divider.sv =====
module tvf_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tvf_pkg::DIV_W-1:0]      dividend,
   input  logic [tvf_pkg::DIV_W-1:0]      divisor,
   input  logic [tvf_pkg::DIV_STEP_W-1:0] steps,
   output logic                           done,
   output logic [tvf_pkg::DIV_W-1:0]      quotient
);
   import tvf_pkg::*;

   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [DIV_W-1:0]      dvd_ff, dvd_in;
   logic [DIV_W-1:0]      dsr_ff, dsr_in;
   logic [DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_W-1:0]      trial;

   assign done      = done_ff;
   assign quotient  = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DIV_W-2:0], dvd_ff[DIV_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = '0;
         // align so that the first step takes the top bit of the used range
         dvd_in  = dividend << (FULL_STEPS - steps);
         dsr_in  = divisor;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         if (trial >= dsr_ff) begin
            rem_in = trial - dsr_ff;
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ===== rtl/tvf_back.sv =====
module tvf_back #(
   parameter int VOXEL_COUNT = tvf_pkg::VOXEL_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  tvf_pkg::cfg_type cfg,
   output logic             clearing,
   input  logic             cmd_empty,
   input  tvf_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output tvf_pkg::rsp_type rsp_data
);
   import tvf_pkg::*;

   localparam int AW = $clog2(VOXEL_COUNT);
   localparam int MW = 46;
   // ceil(2^40 / VOXEL_COUNT): exact quotient for any 16-bit index when VOXEL_COUNT exceeds 128
   localparam longint unsigned RECIP_WIDE =
      ((64'd1 << 40) + 64'(VOXEL_COUNT) - 64'd1) / 64'(VOXEL_COUNT);
   localparam logic [32:0] RECIP = 33'(RECIP_WIDE);

   back_state_type state_ff, state_in;
   cmd_type        cur_ff, cur_in;
   rsp_type        res_ff, res_in;
   logic [AW-1:0]  slot_ff, slot_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [MW-1:0]  mem [VOXEL_COUNT];
   logic [MW-1:0]  rdata_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [MW-1:0]  mem_wdata;

   logic [8:0]          modq_ff, modq_in;
   logic [48:0]         recip_prod;
   logic [31:0]         mod_rem;

   logic [29:0]         w_ff, w_in;
   logic [30:0]         wsum_ff, wsum_in;
   logic signed [46:0]  p_old_ff, p_old_in, p_new_ff, p_new_in;
   logic signed [47:0]  num_ff, num_in;
   logic [47:0]         mag_ff, mag_in;
   logic                neg_ff, neg_in;

   logic                  div_start;
   logic [DIV_W-1:0]      div_dividend, div_divisor;
   logic [DIV_STEP_W-1:0] div_steps;
   logic                  div_done;
   logic [DIV_W-1:0]      div_quo;

   logic signed [15:0]  old_dist;
   logic [29:0]         old_weight;
   logic [15:0]         new_dist;
   logic [29:0]         new_weight;

   function automatic rsp_type make_rsp(logic [15:0] idx, logic [15:0] dist_val,
                                        logic [29:0] wt, logic skip,
                                        logic [14:0] unobs);
      rsp_type r;
      r.result_index    = idx;
      r.result_distance = (wt == '0) ? $signed({1'b0, unobs}) : $signed(dist_val);
      r.result_weight   = wt;
      r.skipped         = skip;
      r.observed        = (wt != '0);
      return r;
   endfunction

   tvf_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .done      (div_done),
      .quotient  (div_quo)
   );

   assign old_dist   = $signed(rdata_ff[45:30]);
   assign old_weight = rdata_ff[29:0];
   assign clearing   = (state_ff == B_CLEAR);
   assign rsp_data   = res_ff;
   assign recip_prod = 49'(cur_ff.voxel_index) * 49'(RECIP);
   assign mod_rem    = {16'd0, cur_ff.voxel_index} - 32'(modq_ff) * 32'(VOXEL_COUNT);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      modq_in      = modq_ff;
      w_in         = w_ff;
      wsum_in      = wsum_ff;
      p_old_in     = p_old_ff;
      p_new_in     = p_new_ff;
      num_in       = num_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      div_steps    = FULL_STEPS;
      new_dist     = neg_ff ? (16'd0 - div_quo[15:0]) : div_quo[15:0];
      new_weight   = (wsum_ff > {1'b0, cfg.weight_cap}) ? cfg.weight_cap : wsum_ff[29:0];

      case (state_ff)
         B_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(VOXEL_COUNT - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd_data;
               state_in = B_MOD;
            end
         end
         B_MOD: begin
            modq_in  = recip_prod[48:40];
            state_in = B_SLOT;
         end
         B_SLOT: begin
            slot_in  = mod_rem[AW-1:0];
            state_in = B_RD;
         end
         B_RD: begin
            state_in = B_DECIDE;
         end
         B_DECIDE: begin
            if (cur_ff.is_read || cur_ff.far) begin
               res_in   = make_rsp(cur_ff.voxel_index, old_dist, old_weight,
                                   !cur_ff.is_read, cfg.unobserved_distance);
               state_in = B_EMIT;
            end else begin
               div_start    = 1'b1;
               div_dividend = cur_ff.w_num;
               div_divisor  = cur_ff.w_den;
               div_steps    = FULL_STEPS;
               state_in     = B_WDIV;
            end
         end
         B_WDIV: begin
            if (div_done) begin
               w_in = (div_quo > DIV_W'(WEIGHT_MAX)) ? WEIGHT_MAX : div_quo[29:0];
               if (div_quo == '0) begin
                  res_in   = make_rsp(cur_ff.voxel_index, old_dist, old_weight,
                                      1'b1, cfg.unobserved_distance);
                  state_in = B_EMIT;
               end else begin
                  state_in = B_MUL;
               end
            end
         end
         B_MUL: begin
            p_old_in = $signed({1'b0, old_weight}) * old_dist;
            p_new_in = $signed({1'b0, w_ff}) * cur_ff.signed_distance;
            wsum_in  = {1'b0, old_weight} + {1'b0, w_ff};
            state_in = B_SUM;
         end
         B_SUM: begin
            num_in   = 48'(p_old_ff) + 48'(p_new_ff);
            state_in = B_ABS;
         end
         B_ABS: begin
            neg_in   = num_ff[47];
            mag_in   = num_ff[47] ? 48'(-num_ff) : 48'(num_ff);
            state_in = B_START;
         end
         B_START: begin
            // round half away from zero on the magnitude
            div_start    = 1'b1;
            div_dividend = mag_ff + {18'd0, wsum_ff[30:1]};
            div_divisor  = {17'd0, wsum_ff};
            div_steps    = FULL_STEPS;
            state_in     = B_ADIV;
         end
         B_ADIV: begin
            if (div_done) begin
               mem_we    = 1'b1;
               mem_wdata = {new_dist, new_weight};
               res_in    = make_rsp(cur_ff.voxel_index, new_dist, new_weight, 1'b0,
                                    cfg.unobserved_distance);
               state_in  = B_EMIT;
            end
         end
         B_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      res_ff   <= res_in;
      slot_ff  <= slot_in;
      modq_ff  <= modq_in;
      w_ff     <= w_in;
      wsum_ff  <= wsum_in;
      p_old_ff <= p_old_in;
      p_new_ff <= p_new_in;
      num_ff   <= num_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[slot_ff];
   end

endmodule

// ===== rtl/tsdf_voxel_fusion.sv =====
// Truncated signed distance voxel fusion.
//
// Input queue: present a request on req_data and raise push; it transfers on
// a clock edge with push high and full low. Each request yields exactly one
// response, in order, on rsp_data while empty is low; pop takes it.
// A read or a sample beyond the cut-off goes straight from the table read to
// its response; a sample whose weight comes out zero ends after the weight
// division, and a fuse runs a 48-step weight division and a 48-step averaging
// division on one radix-2 divider in the back end. The back end works on one
// request at a time and takes no new command until the last response is
// pushed. A front stage and a two-entry command queue take new requests
// while the back end is busy; a two-entry response queue lets the back end
// finish while the receiver stalls, and a full response queue stalls it.
// Reset clears the voxel table with a sweep over all VOXEL_COUNT entries,
// during which full stays high; register writes on the APB-style port are
// taken at any time but belong to idle periods.
module tsdf_voxel_fusion #(
   parameter int VOXEL_COUNT = tvf_pkg::VOXEL_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tvf_pkg::req_type req_data,
   output logic             full,
   input  logic             pop,
   output tvf_pkg::rsp_type rsp_data,
   output logic             empty,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import tvf_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type csr_sel;
   logic          clearing, front_holding, accept;
   logic          cmd_full, cmd_push, cmd_empty, cmd_pop;
   cmd_type       cmd_wdata, cmd_rdata;
   logic          rsp_full, rsp_push;
   rsp_type       rsp_wdata;

   assign pready  = 1'b1;
   assign csr_sel = csr_index_type'(paddr[3:2]);
   assign full    = clearing || (front_holding && cmd_full);
   assign accept  = push && !full;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      case (csr_sel)
         CSR_DROP_START: prdata = {17'd0, cfg_ff.drop_start};
         CSR_DROP_END:   prdata = {17'd0, cfg_ff.drop_end};
         CSR_WEIGHT_CAP: prdata = {2'd0, cfg_ff.weight_cap};
         CSR_UNOBSERVED: prdata = {17'd0, cfg_ff.unobserved_distance};
         default:        prdata = '0;
      endcase
      if (psel && penable && pwrite) begin
         case (csr_sel)
            CSR_DROP_START: cfg_in.drop_start          = pwdata[14:0];
            CSR_DROP_END:   cfg_in.drop_end            = pwdata[14:0];
            CSR_WEIGHT_CAP: cfg_in.weight_cap          = pwdata[29:0];
            CSR_UNOBSERVED: cfg_in.unobserved_distance = pwdata[14:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drop_start          <= 15'd51;
         cfg_ff.drop_end            <= 15'd205;
         cfg_ff.weight_cap          <= 30'd655360000;
         cfg_ff.unobserved_distance <= 15'd154;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tvf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .accept_data (req_data),
      .cfg         (cfg_ff),
      .holding     (front_holding),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_wdata)
   );

   tvf_fifo #(.item_type(cmd_type)) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wdata),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rdata),
      .empty     (cmd_empty)
   );

   tvf_back #(.VOXEL_COUNT(VOXEL_COUNT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .clearing  (clearing),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata)
   );

   tvf_fifo #(.item_type(rsp_type)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wdata),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule

// ===== rtl/tvf_checker.sv =====
module tvf_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input tvf_pkg::rsp_type rsp_data
);
   import tvf_pkg::*;

   a_clear_blocks_input: assert property (@(posedge clock) reset |=> full)
      else $error("input open right after reset");

   a_reset_empties: assert property (@(posedge clock) reset |=> empty)
      else $error("response pending right after reset");

   a_observed_flag: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.observed == (rsp_data.result_weight != '0)))
      else $error("observed flag disagrees with weight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind tsdf_voxel_fusion tvf_checker u_tvf_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
